// ===== rtl/rotate_project_point_assert.svh =====
// Assertion macros shared by the point rotation and projection pipeline.
`ifndef ROTATE_PROJECT_POINT_ASSERT_SVH
`define ROTATE_PROJECT_POINT_ASSERT_SVH

`ifndef SYNTHESIS
`define RPP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rotate_project_point: assertion failed");
`define RPP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rotate_project_point: assertion failed");
`else
`define RPP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RPP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/rpp_pkg.sv =====
`timescale 1ns / 1ps
package rpp_pkg;

  localparam int COORD_BITS = 16;

  localparam int TRIG_W     = 16;
  localparam int TRIG_SHIFT = 14;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int DEPTH_W    = 24;
  localparam int SF_W       = 24;

  // Widths of the rotation intermediates, four margin bits per level.
  localparam int A_W = COORD_BITS + 4;
  localparam int B_W = A_W + 4;
  localparam int R_W = B_W + 4;

  localparam int PA_W = TRIG_W + COORD_BITS;
  localparam int PB_W = TRIG_W + A_W;
  localparam int PC_W = TRIG_W + B_W;
  localparam int A_SUM_W = A_W + TRIG_SHIFT;
  localparam int B_SUM_W = B_W + TRIG_SHIFT;
  localparam int R_SUM_W = R_W + TRIG_SHIFT;

  // Projection datapath widths.
  localparam int DEN_SUM_W = B_W + 2;
  localparam int DEN_POS_W = B_W + 1;
  localparam int D_W       = DEN_POS_W + CFG_W;
  localparam int MX_W      = R_W + CFG_W + 1;
  localparam int NUM_W     = MX_W + 8;
  localparam int DIV_Q     = (COORD_BITS > 24) ? COORD_BITS : 24;
  localparam int CMP_W     = D_W + DIV_Q;

  localparam logic [CFG_IDX_W-1:0] REG_SIN_X  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COS_X  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SIN_Y  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_COS_Y  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_SIN_Z  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_COS_Z  = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL  = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_DSCALE = CFG_IDX_W'(7);

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_x;
    logic signed [TRIG_W-1:0] cos_x;
    logic signed [TRIG_W-1:0] sin_y;
    logic signed [TRIG_W-1:0] cos_y;
    logic signed [TRIG_W-1:0] sin_z;
    logic signed [TRIG_W-1:0] cos_z;
    logic [CFG_W-1:0]         focal;
    logic [CFG_W-1:0]         dscale;
  } rpp_cfg_t;

  localparam rpp_cfg_t CFG_RESET = '{
    sin_x:  16'sd0,
    cos_x:  16'sd16384,
    sin_y:  16'sd0,
    cos_y:  16'sd16384,
    sin_z:  16'sd0,
    cos_z:  16'sd16384,
    focal:  16'd256,
    dscale: 16'd256
  };

  typedef struct packed {
    logic signed [R_W-1:0] rx;
    logic signed [R_W-1:0] ry;
    logic signed [B_W-1:0] rz;
    logic                  last;
  } rpp_rot_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] screen_x;
    logic signed [COORD_BITS-1:0] screen_y;
    logic signed [DEPTH_W-1:0]    depth;
    logic [SF_W-1:0]              scale_factor;
    logic                         behind_viewer;
    logic                         last_out;
  } rpp_res_t;

endpackage

// ===== rtl/rpp_if.sv =====
`timescale 1ns / 1ps
interface rpp_in_if import rpp_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;
  logic                         last_point;

  modport source (output valid, output point_x, output point_y, output point_z,
                  output last_point, input ready);
  modport sink (input valid, input point_x, input point_y, input point_z,
                input last_point, output ready);
endinterface

interface rpp_out_if import rpp_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] screen_x;
  logic signed [COORD_BITS-1:0] screen_y;
  logic signed [DEPTH_W-1:0]    depth;
  logic [SF_W-1:0]              scale_factor;
  logic                         behind_viewer;
  logic                         last_out;

  modport source (output valid, output screen_x, output screen_y, output depth,
                  output scale_factor, output behind_viewer, output last_out,
                  input ready);
  modport sink (input valid, input screen_x, input screen_y, input depth,
                input scale_factor, input behind_viewer, input last_out,
                output ready);
endinterface

// ===== rtl/rpp_rotate.sv =====
`timescale 1ns / 1ps
`include "rotate_project_point_assert.svh"
module rpp_rotate import rpp_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  rpp_cfg_t                     cfg_i,
  input  logic signed [COORD_BITS-1:0] x_i,
  input  logic signed [COORD_BITS-1:0] y_i,
  input  logic signed [COORD_BITS-1:0] z_i,
  input  logic                         last_i,
  output logic                         valid_o,
  output rpp_rot_t                     rot_o
);

  logic signed [PA_W-1:0]       pa_d [4];
  logic signed [PA_W-1:0]       pa_q [4];
  logic signed [COORD_BITS-1:0] x1_q, x2_q;
  logic signed [A_SUM_W-1:0]    sa0, sa1, sa0t, sa1t;
  logic signed [A_W-1:0]        ya_d, za_d, ya2_q, za2_q, ya3_q, ya4_q;
  logic signed [PB_W-1:0]       pb_d [4];
  logic signed [PB_W-1:0]       pb_q [4];
  logic signed [B_SUM_W-1:0]    sb0, sb1, sb0t, sb1t;
  logic signed [B_W-1:0]        rz_d, xb_d, rz4_q, xb4_q, rz5_q, rz6_q;
  logic signed [PC_W-1:0]       pc_d [4];
  logic signed [PC_W-1:0]       pc_q [4];
  logic signed [R_SUM_W-1:0]    sc0, sc1, sc0t, sc1t;
  logic signed [R_W-1:0]        rx_d, ry_d, rx6_q, ry6_q;
  logic [6:1]                   last_q;
  logic [6:1]                   v_q;

  // Each rotation is a product stage followed by a sum and truncate stage.
  // Adding 2^14-1 to a negative sum before the shift rounds toward zero.
  always_comb begin
    pa_d[0] = PA_W'($signed(cfg_i.cos_x)) * PA_W'(y_i);
    pa_d[1] = PA_W'($signed(cfg_i.sin_x)) * PA_W'(z_i);
    pa_d[2] = PA_W'($signed(cfg_i.sin_x)) * PA_W'(y_i);
    pa_d[3] = PA_W'($signed(cfg_i.cos_x)) * PA_W'(z_i);

    sa0  = A_SUM_W'(pa_q[0]) - A_SUM_W'(pa_q[1]);
    sa1  = A_SUM_W'(pa_q[2]) + A_SUM_W'(pa_q[3]);
    sa0t = sa0 + $signed({{(A_SUM_W-TRIG_SHIFT){1'b0}}, {TRIG_SHIFT{sa0[A_SUM_W-1]}}});
    sa1t = sa1 + $signed({{(A_SUM_W-TRIG_SHIFT){1'b0}}, {TRIG_SHIFT{sa1[A_SUM_W-1]}}});
    ya_d = sa0t[TRIG_SHIFT +: A_W];
    za_d = sa1t[TRIG_SHIFT +: A_W];

    pb_d[0] = PB_W'($signed(cfg_i.cos_y)) * PB_W'(za2_q);
    pb_d[1] = PB_W'($signed(cfg_i.sin_y)) * PB_W'(x2_q);
    pb_d[2] = PB_W'($signed(cfg_i.sin_y)) * PB_W'(za2_q);
    pb_d[3] = PB_W'($signed(cfg_i.cos_y)) * PB_W'(x2_q);

    sb0  = B_SUM_W'(pb_q[0]) - B_SUM_W'(pb_q[1]);
    sb1  = B_SUM_W'(pb_q[2]) + B_SUM_W'(pb_q[3]);
    sb0t = sb0 + $signed({{(B_SUM_W-TRIG_SHIFT){1'b0}}, {TRIG_SHIFT{sb0[B_SUM_W-1]}}});
    sb1t = sb1 + $signed({{(B_SUM_W-TRIG_SHIFT){1'b0}}, {TRIG_SHIFT{sb1[B_SUM_W-1]}}});
    rz_d = sb0t[TRIG_SHIFT +: B_W];
    xb_d = sb1t[TRIG_SHIFT +: B_W];

    pc_d[0] = PC_W'($signed(cfg_i.cos_z)) * PC_W'(xb4_q);
    pc_d[1] = PC_W'($signed(cfg_i.sin_z)) * PC_W'(ya4_q);
    pc_d[2] = PC_W'($signed(cfg_i.sin_z)) * PC_W'(xb4_q);
    pc_d[3] = PC_W'($signed(cfg_i.cos_z)) * PC_W'(ya4_q);

    sc0  = R_SUM_W'(pc_q[0]) - R_SUM_W'(pc_q[1]);
    sc1  = R_SUM_W'(pc_q[2]) + R_SUM_W'(pc_q[3]);
    sc0t = sc0 + $signed({{(R_SUM_W-TRIG_SHIFT){1'b0}}, {TRIG_SHIFT{sc0[R_SUM_W-1]}}});
    sc1t = sc1 + $signed({{(R_SUM_W-TRIG_SHIFT){1'b0}}, {TRIG_SHIFT{sc1[R_SUM_W-1]}}});
    rx_d = sc0t[TRIG_SHIFT +: R_W];
    ry_d = sc1t[TRIG_SHIFT +: R_W];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q   <= pa_d;
      x1_q   <= x_i;
      ya2_q  <= ya_d;
      za2_q  <= za_d;
      x2_q   <= x1_q;
      pb_q   <= pb_d;
      ya3_q  <= ya2_q;
      rz4_q  <= rz_d;
      xb4_q  <= xb_d;
      ya4_q  <= ya3_q;
      pc_q   <= pc_d;
      rz5_q  <= rz4_q;
      rx6_q  <= rx_d;
      ry6_q  <= ry_d;
      rz6_q  <= rz5_q;
      last_q <= {last_q[5:1], last_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[5:1], valid_i};
    end
  end

  assign valid_o    = v_q[6];
  assign rot_o.rx   = rx6_q;
  assign rot_o.ry   = ry6_q;
  assign rot_o.rz   = rz6_q;
  assign rot_o.last = last_q[6];

  `RPP_ASSERT_NXT(a_rot_entry, clk_i, rst_ni, en_i, v_q[1] == $past(valid_i))

endmodule

// ===== rtl/rpp_project.sv =====
`timescale 1ns / 1ps
`include "rotate_project_point_assert.svh"
module rpp_project import rpp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  rpp_cfg_t cfg_i,
  input  rpp_rot_t rot_i,
  output logic     valid_o,
  output rpp_res_t res_o
);

  localparam int NUM_LANES = 4;
  localparam int LANE_SF   = 0;
  localparam int LANE_X    = 1;
  localparam int LANE_Y    = 2;
  localparam int LANE_DEP  = 3;

  typedef struct packed {
    logic                 behind;
    logic                 last;
    logic [NUM_LANES-1:0] ovf;
    logic [NUM_LANES-1:0] neg;
  } rpp_side_t;

  // Front stage: denominator, sign check and the products.
  logic signed [DEN_SUM_W-1:0] den_sum;
  logic [CFG_W-1:0]            ds_eff;
  logic signed [MX_W-1:0]      mx_d, my_d, mx1_q, my1_q;
  logic [D_W-1:0]              dd_d, dd1_q;
  logic [DEN_POS_W-1:0]        den1_q;
  logic signed [B_W-1:0]       rz1_q;
  logic [CFG_W-1:0]            ds1_q;
  logic                        behind1_q, last1_q, v1_q;

  // Divider setup and the restoring steps, one quotient bit per stage.
  logic [MX_W-1:0]  mxa, mya;
  logic [B_W-1:0]   rza;
  logic [NUM_W-1:0] num_d [NUM_LANES];
  logic [D_W-1:0]   dvs_d [NUM_LANES];
  rpp_side_t        side_d;
  logic [NUM_W-1:0] rem_q [NUM_LANES][DIV_Q+1];
  logic [D_W-1:0]   dvs_q [NUM_LANES][DIV_Q+1];
  logic [DIV_Q-1:0] quo_q [NUM_LANES][DIV_Q+1];
  logic [NUM_W-1:0] rem_d [NUM_LANES][DIV_Q];
  logic [DIV_Q-1:0] quo_d [NUM_LANES][DIV_Q];
  rpp_side_t        side_q [DIV_Q+1];
  logic [DIV_Q:0]   dv_q;

  rpp_res_t res_d, res_q;
  logic     vs_q;

  function automatic logic [COORD_BITS-1:0] sat_coord(input logic neg, input logic ovf,
                                                      input logic [DIV_Q-1:0] quo);
    logic [DIV_Q-1:0]      lim;
    logic [COORD_BITS-1:0] mag;
    lim = DIV_Q'({(COORD_BITS-1){1'b1}});
    mag = quo[COORD_BITS-1:0];
    if (!neg) begin
      return (ovf || quo > lim) ? {1'b0, {(COORD_BITS-1){1'b1}}} : mag;
    end
    return (ovf || quo > lim + 1'b1) ? {1'b1, {(COORD_BITS-1){1'b0}}} : -mag;
  endfunction

  function automatic logic [DEPTH_W-1:0] sat_depth(input logic neg, input logic ovf,
                                                   input logic [DIV_Q-1:0] quo);
    logic [DIV_Q-1:0]   lim;
    logic [DEPTH_W-1:0] mag;
    lim = DIV_Q'({(DEPTH_W-1){1'b1}});
    mag = quo[DEPTH_W-1:0];
    if (!neg) begin
      return (ovf || quo > lim) ? {1'b0, {(DEPTH_W-1){1'b1}}} : mag;
    end
    return (ovf || quo > lim + 1'b1) ? {1'b1, {(DEPTH_W-1){1'b0}}} : -mag;
  endfunction

  always_comb begin
    ds_eff  = (cfg_i.dscale == '0) ? CFG_W'(1) : cfg_i.dscale;
    den_sum = DEN_SUM_W'(rot_i.rz) + DEN_SUM_W'($signed({1'b0, cfg_i.focal}));
    mx_d    = MX_W'(rot_i.rx) * MX_W'($signed({1'b0, cfg_i.focal}));
    my_d    = MX_W'(rot_i.ry) * MX_W'($signed({1'b0, cfg_i.focal}));
    dd_d    = D_W'(den_sum[DEN_POS_W-1:0]) * D_W'(ds_eff);
  end

  // Every division runs on magnitudes; the quotient sign is kept aside so
  // that truncation goes toward zero.
  always_comb begin
    mxa = mx1_q[MX_W-1] ? $unsigned(-mx1_q) : $unsigned(mx1_q);
    mya = my1_q[MX_W-1] ? $unsigned(-my1_q) : $unsigned(my1_q);
    rza = rz1_q[B_W-1] ? $unsigned(-rz1_q) : $unsigned(rz1_q);

    num_d[LANE_SF]  = NUM_W'({cfg_i.focal, 16'h0000});
    dvs_d[LANE_SF]  = D_W'(den1_q);
    num_d[LANE_X]   = NUM_W'(mxa) << 8;
    dvs_d[LANE_X]   = dd1_q;
    num_d[LANE_Y]   = NUM_W'(mya) << 8;
    dvs_d[LANE_Y]   = dd1_q;
    num_d[LANE_DEP] = NUM_W'(rza) << 16;
    dvs_d[LANE_DEP] = D_W'(ds1_q);

    side_d.behind         = behind1_q;
    side_d.last           = last1_q;
    side_d.neg[LANE_SF]   = 1'b0;
    side_d.neg[LANE_X]    = mx1_q[MX_W-1];
    side_d.neg[LANE_Y]    = my1_q[MX_W-1];
    side_d.neg[LANE_DEP]  = !rz1_q[B_W-1] && (rz1_q != '0);
    for (int l = 0; l < NUM_LANES; l++) begin
      side_d.ovf[l] = CMP_W'(num_d[l]) >= (CMP_W'(dvs_d[l]) << DIV_Q);
    end
  end

  always_comb begin
    logic [CMP_W-1:0] trial;
    logic [CMP_W-1:0] rem_ext;
    logic             fit;
    for (int j = 0; j < DIV_Q; j++) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        trial       = CMP_W'(dvs_q[l][j]) << (DIV_Q - 1 - j);
        rem_ext     = CMP_W'(rem_q[l][j]);
        fit         = rem_ext >= trial;
        rem_d[l][j] = fit ? NUM_W'(rem_ext - trial) : rem_q[l][j];
        quo_d[l][j] = {quo_q[l][j][DIV_Q-2:0], fit};
      end
    end
  end

  always_comb begin
    res_d.behind_viewer = side_q[DIV_Q].behind;
    res_d.last_out      = side_q[DIV_Q].last;
    if (side_q[DIV_Q].behind) begin
      res_d.screen_x     = '0;
      res_d.screen_y     = '0;
      res_d.depth        = '0;
      res_d.scale_factor = '0;
    end else begin
      res_d.screen_x = sat_coord(side_q[DIV_Q].neg[LANE_X], side_q[DIV_Q].ovf[LANE_X],
                                 quo_q[LANE_X][DIV_Q]);
      res_d.screen_y = sat_coord(side_q[DIV_Q].neg[LANE_Y], side_q[DIV_Q].ovf[LANE_Y],
                                 quo_q[LANE_Y][DIV_Q]);
      res_d.depth    = sat_depth(side_q[DIV_Q].neg[LANE_DEP], side_q[DIV_Q].ovf[LANE_DEP],
                                 quo_q[LANE_DEP][DIV_Q]);
      if (side_q[DIV_Q].ovf[LANE_SF] ||
          quo_q[LANE_SF][DIV_Q] > DIV_Q'({SF_W{1'b1}})) begin
        res_d.scale_factor = {SF_W{1'b1}};
      end else begin
        res_d.scale_factor = quo_q[LANE_SF][DIV_Q][SF_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mx1_q     <= mx_d;
      my1_q     <= my_d;
      dd1_q     <= dd_d;
      den1_q    <= den_sum[DEN_POS_W-1:0];
      rz1_q     <= rot_i.rz;
      ds1_q     <= ds_eff;
      behind1_q <= den_sum[DEN_SUM_W-1] || (den_sum == '0);
      last1_q   <= rot_i.last;
      side_q[0] <= side_d;
      for (int l = 0; l < NUM_LANES; l++) begin
        rem_q[l][0] <= num_d[l];
        dvs_q[l][0] <= dvs_d[l];
        quo_q[l][0] <= '0;
      end
      for (int j = 0; j < DIV_Q; j++) begin
        side_q[j+1] <= side_q[j];
        for (int l = 0; l < NUM_LANES; l++) begin
          rem_q[l][j+1] <= rem_d[l][j];
          dvs_q[l][j+1] <= dvs_q[l][j];
          quo_q[l][j+1] <= quo_d[l][j];
        end
      end
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      dv_q <= '0;
      vs_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      dv_q <= {dv_q[DIV_Q-1:0], v1_q};
      vs_q <= dv_q[DIV_Q];
    end
  end

  assign valid_o = vs_q;
  assign res_o   = res_q;

  `RPP_ASSERT_NXT(a_sat_follows_div, clk_i, rst_ni, en_i, vs_q == $past(dv_q[DIV_Q]))

endmodule

// ===== rtl/rotate_project_point.sv =====
`timescale 1ns / 1ps
// An accepted point reaches the output register through six rotation stages, two projection
// setup stages, 24 divider steps, a saturation stage and the output register.
// Throughput: one point per cycle; the whole pipeline holds while the output is stalled.
// The quotient bits come from a restoring divider that retires one bit per stage.
// Reset (rst_ni low, asynchronous) clears all valid bits and loads the identity rotation,
// focal length 256 and depth scale 256.
`include "rotate_project_point_assert.svh"
module rotate_project_point import rpp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  rpp_in_if.sink               in_if,
  rpp_out_if.source            out_if
);

  rpp_cfg_t cfg_q;
  rpp_rot_t rot;
  rpp_res_t proj_res, res_q;
  logic     rot_valid, proj_valid, out_valid_q, en;

  // The pipeline advances whenever the output register is free or drained.
  assign en          = !out_valid_q || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SIN_X:  cfg_q.sin_x  <= cfg_data_i;
        REG_COS_X:  cfg_q.cos_x  <= cfg_data_i;
        REG_SIN_Y:  cfg_q.sin_y  <= cfg_data_i;
        REG_COS_Y:  cfg_q.cos_y  <= cfg_data_i;
        REG_SIN_Z:  cfg_q.sin_z  <= cfg_data_i;
        REG_COS_Z:  cfg_q.cos_z  <= cfg_data_i;
        REG_FOCAL:  cfg_q.focal  <= cfg_data_i;
        REG_DSCALE: cfg_q.dscale <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rpp_rotate u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_if.valid),
    .cfg_i   (cfg_q),
    .x_i     (in_if.point_x),
    .y_i     (in_if.point_y),
    .z_i     (in_if.point_z),
    .last_i  (in_if.last_point),
    .valid_o (rot_valid),
    .rot_o   (rot)
  );

  rpp_project u_project (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rot_valid),
    .cfg_i   (cfg_q),
    .rot_i   (rot),
    .valid_o (proj_valid),
    .res_o   (proj_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= proj_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= proj_res;
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.screen_x      = res_q.screen_x;
  assign out_if.screen_y      = res_q.screen_y;
  assign out_if.depth         = res_q.depth;
  assign out_if.scale_factor  = res_q.scale_factor;
  assign out_if.behind_viewer = res_q.behind_viewer;
  assign out_if.last_out      = res_q.last_out;

  `RPP_ASSERT_IMP(a_behind_zero, clk_i, rst_ni, out_valid_q && res_q.behind_viewer, res_q.screen_x == '0 && res_q.screen_y == '0 && res_q.depth == '0 && res_q.scale_factor == '0)

endmodule
